[rtl/rrts_pkg.sv]
// Shared types and constants of the round robin thread scheduler.
`default_nettype none
package rrts_pkg;

  localparam int NUM_SLOTS  = 16;
  localparam int SLOT_W     = 4;
  localparam int NUM_QUEUES = 16;
  localparam int QUEUE_W    = 4;
  localparam int TICK_W     = 32;
  localparam int PRIO_W     = 7;
  localparam int HEAD_W     = SLOT_W + 1;

  localparam logic [PRIO_W-1:0] PRIO_NONE = 7'd100;
  localparam logic [HEAD_W-1:0] NO_SLOT   = 5'h10;

  localparam logic [1:0] TS_RUN      = 2'd0;
  localparam logic [1:0] TS_SLEEP    = 2'd1;
  localparam logic [1:0] TS_BLOCK    = 2'd2;
  localparam logic [1:0] TS_BLOCK_TO = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NO_SLOT = 2'd1;
  localparam logic [1:0] STAT_IDLE    = 2'd2;
  localparam logic [1:0] STAT_NO_WAKE = 2'd3;

  typedef enum logic [3:0] {
    K_TICK       = 4'd0,
    K_CREATE     = 4'd1,
    K_REMOVE     = 4'd2,
    K_YIELD      = 4'd3,
    K_SLEEP      = 4'd4,
    K_BLOCK      = 4'd5,
    K_BLOCK_TO   = 4'd6,
    K_WAKEUP     = 4'd7,
    K_PRIO_YIELD = 4'd8,
    K_SET_PRIO   = 4'd9
  } kind_e;

  typedef enum logic [1:0] {
    RING_NONE,
    RING_ADD,
    RING_UNLINK
  } ring_op_e;

  typedef struct packed {
    ring_op_e            op;
    logic                use_head;
    logic [HEAD_W-1:0]   head;
    logic [SLOT_W-1:0]   slot;
  } ring_req_t;

  typedef struct packed {
    logic [HEAD_W-1:0]   head;
    logic [SLOT_W-1:0]   rd_next;
  } ring_rsp_t;

endpackage
`default_nettype wire

[rtl/rrts_if.sv]
// Channel interfaces of the round robin thread scheduler.
`default_nettype none
interface rrts_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [3:0]  thread_id;
  logic        use_current;
  logic [15:0] tick_count_arg;
  logic [6:0]  prio_value;
  logic [3:0]  wait_queue;
  modport source (output valid, kind, thread_id, use_current, tick_count_arg, prio_value,
                  wait_queue, input ready);
  modport sink (input valid, kind, thread_id, use_current, tick_count_arg, prio_value,
                wait_queue, output ready);
endinterface

interface rrts_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       running_valid;
  logic [3:0] running_thread;
  logic [3:0] created_slot;
  logic [6:0] prev_priority;
  modport source (output valid, status, running_valid, running_thread, created_slot,
                  prev_priority, input ready);
  modport sink (input valid, status, running_valid, running_thread, created_slot,
                prev_priority, output ready);
endinterface

interface rrts_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

[rtl/rrts_ring.sv]
// Link store of the thread rings with one add or unlink operation per cycle.
`default_nettype none
module rrts_ring (
  input  wire                     clk_i,
  input  rrts_pkg::ring_req_t     req_i,
  input  wire [3:0]               rd_slot_i,
  output rrts_pkg::ring_rsp_t     rsp_o
);
  import rrts_pkg::*;

  logic [SLOT_W-1:0] next_q [NUM_SLOTS];
  logic [SLOT_W-1:0] prev_q [NUM_SLOTS];
  logic [SLOT_W-1:0] h, p_add, n_ul, p_ul;
  logic              skip;

  always_comb begin
    h     = req_i.head[SLOT_W-1:0];
    p_add = prev_q[h];
    n_ul  = next_q[req_i.slot];
    p_ul  = prev_q[req_i.slot];
    skip  = req_i.use_head && (n_ul == req_i.slot);
    rsp_o.rd_next = next_q[rd_slot_i];
    rsp_o.head    = req_i.head;
    case (req_i.op)
      RING_ADD: begin
        if (req_i.head[SLOT_W]) begin
          rsp_o.head = {1'b0, req_i.slot};
        end
      end
      RING_UNLINK: begin
        if (skip) begin
          rsp_o.head = NO_SLOT;
        end else if (req_i.head == {1'b0, req_i.slot}) begin
          rsp_o.head = {1'b0, n_ul};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (req_i.op)
      RING_ADD: begin
        if (req_i.head[SLOT_W]) begin
          next_q[req_i.slot] <= req_i.slot;
          prev_q[req_i.slot] <= req_i.slot;
        end else begin
          next_q[req_i.slot] <= h;
          prev_q[req_i.slot] <= p_add;
          next_q[p_add]      <= req_i.slot;
          prev_q[h]          <= req_i.slot;
        end
      end
      RING_UNLINK: begin
        if (!skip) begin
          next_q[p_ul] <= n_ul;
          prev_q[n_ul] <= p_ul;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

[rtl/rrts_cmp.sv]
// Shared tick subtractor used for wake expiry and for priority aging.
`default_nettype none
module rrts_cmp (
  input  wire [31:0] a_i,
  input  wire [31:0] b_i,
  output logic [31:0] diff_o,
  output logic        ge_o
);
  import rrts_pkg::*;

  logic borrow;

  assign {borrow, diff_o} = {1'b0, a_i} - {1'b0, b_i};
  assign ge_o = !borrow;
endmodule
`default_nettype wire

[rtl/rrts_core.sv]
// Sequencer and thread tables of the round robin thread scheduler.
`default_nettype none
module rrts_core (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  prio_en_i,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire [3:0]            kind_i,
  input  wire [3:0]            thread_id_i,
  input  wire                  use_current_i,
  input  wire [15:0]           tick_count_arg_i,
  input  wire [6:0]            prio_value_i,
  input  wire [3:0]            wait_queue_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output logic [1:0]           status_o,
  output logic                 running_valid_o,
  output logic [3:0]           running_thread_o,
  output logic [3:0]           created_slot_o,
  output logic [6:0]           prev_priority_o,
  output rrts_pkg::ring_req_t  ring_req_o,
  output logic [3:0]           ring_rd_slot_o,
  input  rrts_pkg::ring_rsp_t  ring_rsp_i,
  output logic [31:0]          now_tick_o,
  output logic [31:0]          cmp_b_o,
  input  wire [31:0]           cmp_diff_i,
  input  wire                  cmp_ge_i
);
  import rrts_pkg::*;

  localparam int SLP_LIMIT = 2 * NUM_SLOTS;
  localparam int K_W       = $clog2(SLP_LIMIT + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_REM2, S_WAKE2, S_SW1, S_SW2, S_POST, S_SEL0,
    S_SLP, S_SLPADD, S_SEL1, S_PLOOP, S_PNF, S_SELFIN, S_DONE
  } state_e;

  typedef enum logic [1:0] {HS_NONE, HS_RUN, HS_SLEEP, HS_QUEUE} head_sel_e;

  state_e state_q, state_d;

  logic [NUM_SLOTS-1:0] used_q, used_d, yield_q, yield_d;
  logic [1:0]           tstate_q [NUM_SLOTS];
  logic [1:0]           tstate_d [NUM_SLOTS];
  logic [HEAD_W-1:0]    qhead_q  [NUM_QUEUES];
  logic [HEAD_W-1:0]    qhead_d  [NUM_QUEUES];
  logic [TICK_W-1:0]    wake_q   [NUM_SLOTS];
  logic [TICK_W-1:0]    wake_d   [NUM_SLOTS];
  logic [TICK_W-1:0]    lrun_q   [NUM_SLOTS];
  logic [TICK_W-1:0]    lrun_d   [NUM_SLOTS];
  logic [PRIO_W-1:0]    prio_q   [NUM_SLOTS];
  logic [PRIO_W-1:0]    prio_d   [NUM_SLOTS];
  logic [HEAD_W-1:0]    run_head_q, run_head_d, sleep_head_q, sleep_head_d;
  logic [TICK_W-1:0]    now_q, now_d, lchk_q, lchk_d;
  logic [PRIO_W-1:0]    best_q, best_d;

  logic [3:0]           kind_q, kind_d, tid_q, tid_d, cur_q, cur_d, tgt_q, tgt_d;
  logic [QUEUE_W-1:0]   wq_q, wq_d;
  logic                 usecur_q, usecur_d, was_idle_q, was_idle_d;
  logic                 switched_q, switched_d;
  logic [15:0]          targ_q, targ_d;
  logic [PRIO_W-1:0]    pv_q, pv_d, oldp_q, oldp_d;
  logic [1:0]           status_q, status_d;
  logic [SLOT_W-1:0]    created_q, created_d, scur_q, scur_d, snext_q, snext_d;
  logic [K_W-1:0]       k_q, k_d;
  logic [SLOT_W-1:0]    i_q, i_d;

  logic                 out_valid_q, out_valid_d, o_rv_q, o_rv_d;
  logic [1:0]           o_status_q, o_status_d;
  logic [3:0]           o_rt_q, o_rt_d, o_cs_q, o_cs_d;
  logic [6:0]           o_op_q, o_op_d;

  head_sel_e            hsel;
  logic [QUEUE_W-1:0]   hq;
  logic [SLOT_W-1:0]    c, free_slot, tgt, qslot;
  logic                 free_found, tgt_ok, qfound;
  logic [PRIO_W-1:0]    p, bn;
  logic [1:0]           st;

  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign status_o         = o_status_q;
  assign running_valid_o  = o_rv_q;
  assign running_thread_o = o_rt_q;
  assign created_slot_o   = o_cs_q;
  assign prev_priority_o  = o_op_q;
  assign now_tick_o       = now_q;

  always_comb begin
    state_d = state_q;
    used_d = used_q; yield_d = yield_q; tstate_d = tstate_q; qhead_d = qhead_q;
    wake_d = wake_q; lrun_d = lrun_q; prio_d = prio_q;
    run_head_d = run_head_q; sleep_head_d = sleep_head_q;
    now_d = now_q; lchk_d = lchk_q; best_d = best_q;
    kind_d = kind_q; tid_d = tid_q; cur_d = cur_q; tgt_d = tgt_q; wq_d = wq_q;
    usecur_d = usecur_q; was_idle_d = was_idle_q; switched_d = switched_q;
    targ_d = targ_q; pv_d = pv_q; oldp_d = oldp_q; status_d = status_q;
    created_d = created_q; scur_d = scur_q; snext_d = snext_q; k_d = k_q; i_d = i_q;
    out_valid_d = out_valid_q && !out_ready_i;
    o_status_d = o_status_q; o_rv_d = o_rv_q; o_rt_d = o_rt_q;
    o_cs_d = o_cs_q; o_op_d = o_op_q;
    ring_req_o = '{op: RING_NONE, use_head: 1'b1, head: NO_SLOT, slot: '0};
    ring_rd_slot_o = '0;
    hsel = HS_NONE;
    hq = wq_q;
    c = run_head_q[SLOT_W] ? '0 : run_head_q[SLOT_W-1:0];
    cmp_b_o = (state_q == S_SLP) ? wake_q[scur_q] : lrun_q[c];
    p = prio_q[c];
    bn = (p < best_q) ? p : best_q;
    st = tstate_q[c];
    free_slot = '0;
    free_found = 1'b0;
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if (!used_q[s]) begin
        free_slot = SLOT_W'(s);
        free_found = 1'b1;
      end
    end
    tgt = usecur_q ? cur_q : tid_q;
    tgt_ok = (!usecur_q || !was_idle_q) && used_q[tgt];
    qslot = '0;
    qfound = 1'b0;
    for (int q = NUM_QUEUES - 1; q >= 0; q--) begin
      if (qhead_q[q] == {1'b0, tgt} && tstate_q[tgt] == TS_BLOCK) begin
        qslot = QUEUE_W'(q);
        qfound = 1'b1;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d = kind_i; tid_d = thread_id_i; usecur_d = use_current_i;
          targ_d = tick_count_arg_i; pv_d = prio_value_i; wq_d = wait_queue_i;
          was_idle_d = run_head_q[SLOT_W];
          cur_d = c;
          switched_d = 1'b0; status_d = STAT_OK; created_d = '0; oldp_d = '0;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_POST;
        case (kind_q)
          K_TICK: now_d = now_q + TICK_W'(1);
          K_CREATE: begin
            if (!free_found) begin
              status_d = STAT_NO_SLOT;
            end else begin
              used_d[free_slot] = 1'b1;
              tstate_d[free_slot] = TS_RUN;
              yield_d[free_slot] = 1'b0;
              prio_d[free_slot] = pv_q;
              lrun_d[free_slot] = '0;
              best_d = PRIO_NONE;
              ring_req_o = '{op: RING_ADD, use_head: 1'b1, head: run_head_q,
                             slot: free_slot};
              hsel = HS_RUN;
              created_d = free_slot;
            end
          end
          K_SET_PRIO: begin
            if (tgt_ok) begin
              oldp_d = prio_q[tgt];
              prio_d[tgt] = pv_q;
              best_d = PRIO_NONE;
            end
          end
          K_REMOVE: begin
            if (tgt_ok) begin
              tgt_d = tgt;
              used_d[tgt] = 1'b0;
              best_d = PRIO_NONE;
              switched_d = (run_head_q == {1'b0, tgt});
              ring_req_o.op = RING_UNLINK;
              ring_req_o.slot = tgt;
              if (run_head_q == {1'b0, tgt}) begin
                ring_req_o.head = run_head_q;
                hsel = HS_RUN;
              end else if (sleep_head_q == {1'b0, tgt}) begin
                ring_req_o.head = sleep_head_q;
                hsel = HS_SLEEP;
              end else if (qfound) begin
                ring_req_o.head = qhead_q[qslot];
                hsel = HS_QUEUE;
                hq = qslot;
              end else begin
                ring_req_o.use_head = 1'b0;
              end
              state_d = S_REM2;
            end
          end
          K_YIELD: begin
            if (!was_idle_q) begin
              switched_d = 1'b1;
              state_d = S_SW1;
            end
          end
          K_SLEEP: begin
            if (!was_idle_q) begin
              tstate_d[cur_q] = TS_SLEEP;
              wake_d[cur_q] = now_q + TICK_W'(targ_q) + TICK_W'(1);
              switched_d = 1'b1;
              state_d = S_SW1;
            end
          end
          K_BLOCK: begin
            if (!was_idle_q && !(!qhead_q[wq_q][SLOT_W] &&
                tstate_q[qhead_q[wq_q][SLOT_W-1:0]] != TS_BLOCK)) begin
              tstate_d[cur_q] = TS_BLOCK;
              switched_d = 1'b1;
              state_d = S_SW1;
            end
          end
          K_BLOCK_TO: begin
            if (!was_idle_q && qhead_q[wq_q][SLOT_W]) begin
              tstate_d[cur_q] = TS_BLOCK_TO;
              wake_d[cur_q] = now_q + TICK_W'(targ_q);
              qhead_d[wq_q] = {1'b0, cur_q};
              switched_d = 1'b1;
              state_d = S_SW1;
            end
          end
          K_WAKEUP: begin
            tgt_d = qhead_q[wq_q][SLOT_W-1:0];
            if (qhead_q[wq_q][SLOT_W]) begin
              status_d = STAT_NO_WAKE;
            end else if (tstate_q[qhead_q[wq_q][SLOT_W-1:0]] == TS_BLOCK) begin
              ring_req_o = '{op: RING_UNLINK, use_head: 1'b1, head: qhead_q[wq_q],
                             slot: qhead_q[wq_q][SLOT_W-1:0]};
              hsel = HS_QUEUE;
              state_d = S_WAKE2;
            end else if (tstate_q[qhead_q[wq_q][SLOT_W-1:0]] == TS_BLOCK_TO) begin
              tstate_d[qhead_q[wq_q][SLOT_W-1:0]] = TS_RUN;
              wake_d[qhead_q[wq_q][SLOT_W-1:0]] = '0;
            end else begin
              status_d = STAT_NO_WAKE;
            end
          end
          K_PRIO_YIELD: begin
            if (!was_idle_q) begin
              yield_d[cur_q] = 1'b1;
              switched_d = 1'b1;
              state_d = S_SW1;
            end
          end
          default: ;
        endcase
      end
      S_REM2: begin
        for (int q = 0; q < NUM_QUEUES; q++) begin
          if (qhead_q[q] == {1'b0, tgt_q}) begin
            qhead_d[q] = NO_SLOT;
          end
        end
        tstate_d[tgt_q] = TS_RUN;
        yield_d[tgt_q] = 1'b0;
        state_d = switched_q ? S_SEL0 : S_POST;
      end
      S_WAKE2: begin
        ring_req_o = '{op: RING_ADD, use_head: 1'b1, head: run_head_q, slot: tgt_q};
        hsel = HS_RUN;
        tstate_d[tgt_q] = TS_RUN;
        state_d = S_POST;
      end
      S_SW1: begin
        tgt_d = c;
        if (st != TS_RUN) begin
          ring_req_o = '{op: RING_UNLINK, use_head: 1'b1, head: run_head_q, slot: c};
          hsel = HS_RUN;
          state_d = S_SW2;
        end else begin
          ring_rd_slot_o = c;
          run_head_d = {1'b0, ring_rsp_i.rd_next};
          state_d = S_SEL0;
        end
      end
      S_SW2: begin
        ring_req_o.op = RING_ADD;
        ring_req_o.slot = tgt_q;
        if (tstate_q[tgt_q] == TS_BLOCK && kind_q == K_BLOCK) begin
          ring_req_o.head = qhead_q[wq_q];
          hsel = HS_QUEUE;
        end else begin
          ring_req_o.head = sleep_head_q;
          hsel = HS_SLEEP;
        end
        if (prio_q[tgt_q] == best_q) begin
          best_d = PRIO_NONE;
        end
        state_d = S_SEL0;
      end
      S_POST: begin
        state_d = (was_idle_q && !switched_q && kind_q <= K_SET_PRIO) ? S_SEL0 : S_DONE;
      end
      S_SEL0: begin
        state_d = S_SEL1;
        if (lchk_q != now_q) begin
          lchk_d = now_q;
          if (!sleep_head_q[SLOT_W]) begin
            scur_d = sleep_head_q[SLOT_W-1:0];
            k_d = '0;
            state_d = S_SLP;
          end
        end
      end
      S_SLP: begin
        ring_rd_slot_o = scur_q;
        if (k_q >= K_W'(SLP_LIMIT) || sleep_head_q[SLOT_W]) begin
          state_d = S_SEL1;
        end else if (cmp_ge_i) begin
          snext_d = ring_rsp_i.rd_next;
          ring_req_o = '{op: RING_UNLINK, use_head: 1'b1, head: sleep_head_q, slot: scur_q};
          hsel = HS_SLEEP;
          state_d = S_SLPADD;
        end else begin
          scur_d = ring_rsp_i.rd_next;
          k_d = k_q + K_W'(1);
          if ({1'b0, ring_rsp_i.rd_next} == sleep_head_q) begin
            state_d = S_SEL1;
          end
        end
      end
      S_SLPADD: begin
        ring_req_o = '{op: RING_ADD, use_head: 1'b1, head: run_head_q, slot: scur_q};
        hsel = HS_RUN;
        tstate_d[scur_q] = TS_RUN;
        wake_d[scur_q] = '0;
        if (sleep_head_q[SLOT_W]) begin
          state_d = S_SEL1;
        end else begin
          scur_d = snext_q;
          k_d = k_q + K_W'(1);
          state_d = S_SLP;
        end
      end
      S_SEL1: begin
        if (run_head_q[SLOT_W]) begin
          state_d = S_DONE;
        end else if (!prio_en_i) begin
          state_d = S_SELFIN;
        end else begin
          i_d = '0;
          state_d = S_PLOOP;
        end
      end
      S_PLOOP: begin
        best_d = bn;
        if (p == bn || cmp_diff_i > TICK_W'({p, 3'b000}) || yield_q[c]) begin
          state_d = S_SELFIN;
        end else begin
          ring_rd_slot_o = c;
          run_head_d = {1'b0, ring_rsp_i.rd_next};
          i_d = i_q + SLOT_W'(1);
          if (i_q == SLOT_W'(NUM_SLOTS - 1)) begin
            state_d = S_PNF;
          end
        end
      end
      S_PNF: begin
        best_d = p;
        state_d = S_SELFIN;
      end
      S_SELFIN: begin
        lrun_d[c] = now_q;
        yield_d[c] = 1'b0;
        for (int q = 0; q < NUM_QUEUES; q++) begin
          if (qhead_q[q] == {1'b0, c}) begin
            qhead_d[q] = NO_SLOT;
          end
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          o_status_d = (status_q == STAT_OK && run_head_q[SLOT_W]) ? STAT_IDLE : status_q;
          o_rv_d = !run_head_q[SLOT_W];
          o_rt_d = run_head_q[SLOT_W] ? '0 : run_head_q[SLOT_W-1:0];
          o_cs_d = created_q;
          o_op_d = oldp_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (ring_req_o.op != RING_NONE) begin
      case (hsel)
        HS_RUN:   run_head_d = ring_rsp_i.head;
        HS_SLEEP: sleep_head_d = ring_rsp_i.head;
        HS_QUEUE: qhead_d[hq] = ring_rsp_i.head;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q <= '0;
      yield_q <= '0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        tstate_q[s] <= TS_RUN;
      end
      for (int q = 0; q < NUM_QUEUES; q++) begin
        qhead_q[q] <= NO_SLOT;
      end
      run_head_q <= NO_SLOT;
      sleep_head_q <= NO_SLOT;
      now_q <= '0;
      lchk_q <= '0;
      best_q <= PRIO_NONE;
      out_valid_q <= 1'b0;
      o_status_q <= STAT_OK;
      o_rv_q <= 1'b0;
      o_rt_q <= '0;
      o_cs_q <= '0;
      o_op_q <= '0;
    end else begin
      state_q <= state_d;
      used_q <= used_d;
      yield_q <= yield_d;
      tstate_q <= tstate_d;
      qhead_q <= qhead_d;
      run_head_q <= run_head_d;
      sleep_head_q <= sleep_head_d;
      now_q <= now_d;
      lchk_q <= lchk_d;
      best_q <= best_d;
      out_valid_q <= out_valid_d;
      o_status_q <= o_status_d;
      o_rv_q <= o_rv_d;
      o_rt_q <= o_rt_d;
      o_cs_q <= o_cs_d;
      o_op_q <= o_op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wake_q <= wake_d;
    lrun_q <= lrun_d;
    prio_q <= prio_d;
    kind_q <= kind_d;
    tid_q <= tid_d;
    cur_q <= cur_d;
    tgt_q <= tgt_d;
    wq_q <= wq_d;
    usecur_q <= usecur_d;
    was_idle_q <= was_idle_d;
    switched_q <= switched_d;
    targ_q <= targ_d;
    pv_q <= pv_d;
    oldp_q <= oldp_d;
    status_q <= status_d;
    created_q <= created_d;
    scur_q <= scur_d;
    snext_q <= snext_d;
    k_q <= k_d;
    i_q <= i_d;
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_EXEC))
    else $error("accepted item did not start execution");
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result appeared outside the done state");
  a_sleep_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SLP) |-> (k_q <= K_W'(SLP_LIMIT)))
    else $error("sleeper walk ran past its bound");
`endif
endmodule
`default_nettype wire

[rtl/round_robin_thread_scheduler.sv]
// Top level of the round robin thread scheduler with priority aging.
`default_nettype none
// An item that switches threads may walk the sleeping ring, when the tick has moved since
// the last walk, where each expired sleeper is unlinked from it and then added to the
// running ring, and then, with priority aging enabled, the running ring in priority order.
// The sequencer does one ring link operation and one tick compare per cycle.
// The block takes no new item until the result of the current one is in its output
// register; a waiting result does not hold off taking the next item, only its result.
module round_robin_thread_scheduler (
  input  wire         clk_i,
  input  wire         rst_ni,
  rrts_in_if.sink     in_i,
  rrts_out_if.source  out_o,
  rrts_cfg_if.sink    cfg_i
);
  import rrts_pkg::*;

  logic        prio_en_q;
  ring_req_t   ring_req;
  ring_rsp_t   ring_rsp;
  logic [3:0]  ring_rd_slot;
  logic [31:0] cmp_b, cmp_diff, now_tick;
  logic        cmp_ge;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prio_en_q <= 1'b1;
    end else if (cfg_i.valid) begin
      prio_en_q <= cfg_i.data;
    end
  end

  rrts_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .prio_en_i        (prio_en_q),
    .in_valid_i       (in_i.valid),
    .in_ready_o       (in_i.ready),
    .kind_i           (in_i.kind),
    .thread_id_i      (in_i.thread_id),
    .use_current_i    (in_i.use_current),
    .tick_count_arg_i (in_i.tick_count_arg),
    .prio_value_i     (in_i.prio_value),
    .wait_queue_i     (in_i.wait_queue),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .status_o         (out_o.status),
    .running_valid_o  (out_o.running_valid),
    .running_thread_o (out_o.running_thread),
    .created_slot_o   (out_o.created_slot),
    .prev_priority_o  (out_o.prev_priority),
    .ring_req_o       (ring_req),
    .ring_rd_slot_o   (ring_rd_slot),
    .ring_rsp_i       (ring_rsp),
    .now_tick_o       (now_tick),
    .cmp_b_o          (cmp_b),
    .cmp_diff_i       (cmp_diff),
    .cmp_ge_i         (cmp_ge)
  );

  rrts_ring u_ring (
    .clk_i     (clk_i),
    .req_i     (ring_req),
    .rd_slot_i (ring_rd_slot),
    .rsp_o     (ring_rsp)
  );

  rrts_cmp u_cmp (
    .a_i    (now_tick),
    .b_i    (cmp_b),
    .diff_o (cmp_diff),
    .ge_o   (cmp_ge)
  );
endmodule
`default_nettype wire
